[sv/zpba_pkg.sv]
`default_nettype none

package zpba_pkg;

    localparam int MAX_HALF    = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int HALF_BITS   = 4;
    localparam int LINE_DEPTH  = 2 * MAX_HALF + 1;
    localparam int IDX_BITS    = $clog2(LINE_DEPTH);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(LINE_DEPTH);
    localparam int POS_BITS    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_BITS    = 24;
    localparam int DVD_BITS    = SUM_BITS + FRAC_BITS;
    localparam int DIV_BITS    = $clog2(2 * MAX_HALF + 2);
    localparam int CNT_BITS    = $clog2(DVD_BITS);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR    = $clog2(FIFO_DEPTH);

    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(3);

    typedef logic [HALF_BITS-1:0] t_half;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_half eff_half(input t_half h);
        t_half l;
        l = h;
        if (l < t_half'(1)) begin
            l = t_half'(1);
        end
        if (int'(l) > MAX_HALF) begin
            l = t_half'(MAX_HALF);
        end
        return l;
    endfunction

endpackage

`default_nettype wire

[sv/zpba_smp_if.sv]
`default_nettype none

interface zpba_smp_if
    import zpba_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink (input valid, input sample, input last_in, output ready);
endinterface

`default_nettype wire

[sv/zpba_out_if.sv]
`default_nettype none

interface zpba_out_if
    import zpba_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [AVG_BITS-1:0] average;
    logic                last_out;

    modport source (output valid, output average, output last_out, input ready);
    modport sink (input valid, input average, input last_out, output ready);
endinterface

`default_nettype wire

[sv/zpba_cfg_if.sv]
`default_nettype none

interface zpba_cfg_if
    import zpba_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [HALF_BITS-1:0] half_width;

    modport source (output valid, output half_width, input ready);
    modport sink (input valid, input half_width, output ready);
endinterface

`default_nettype wire

[sv/zpba_front.sv]
`default_nettype none

module zpba_front
    import zpba_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_clear,
    input  wire t_half   i_half,
    zpba_smp_if.sink     i_smp,
    input  wire t_q_stat i_stat,
    output logic         o_push,
    output t_job         o_job
);

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } t_state;

    t_state                r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_line [LINE_DEPTH];
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    t_half                 r_k, n_k;

    t_half                 l;
    logic [IDX_BITS-1:0]   span;
    logic [IDX_BITS-1:0]   rd_idx;
    logic [SUM_BITS-1:0]   leave;
    logic                  accept;
    logic                  shift;
    logic                  wipe;

    assign l       = eff_half(i_half);
    assign span    = IDX_BITS'({l, 1'b0});
    assign rd_idx  = (r_state == S_FLUSH) ? IDX_BITS'(span - IDX_BITS'(r_k) + IDX_BITS'(1)) : span;
    assign leave   = SUM_BITS'(r_line[rd_idx]);
    assign i_smp.ready = (r_state == S_IDLE) && !i_stat.full;
    assign accept  = i_smp.valid && i_smp.ready;

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_pos    = r_pos;
        n_k      = r_k;
        shift    = 1'b0;
        wipe     = 1'b0;
        o_push   = 1'b0;
        o_job    = '{sum: r_sum, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    shift     = 1'b1;
                    n_sum     = r_sum - leave + SUM_BITS'(i_smp.sample);
                    o_push    = r_pos >= POS_BITS'(l);
                    o_job.sum = n_sum;
                    if (i_smp.last_in) begin
                        n_state = S_FLUSH;
                        n_k     = t_half'(1);
                    end else if (r_pos != '1) begin
                        n_pos = r_pos + POS_BITS'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.full) begin
                    n_sum      = r_sum - leave;
                    o_push     = ((POS_BITS + 1)'(r_pos) + (POS_BITS + 1)'(r_k))
                                 >= (POS_BITS + 1)'(l);
                    o_job.sum  = n_sum;
                    o_job.last = (r_k == l);
                    if (r_k == l) begin
                        wipe    = 1'b1;
                        n_state = S_IDLE;
                        n_sum   = '0;
                        n_pos   = '0;
                    end else begin
                        n_k = r_k + t_half'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_pos   <= '0;
            r_k     <= t_half'(1);
            for (int i = 0; i < LINE_DEPTH; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_k     <= n_k;
            if (wipe) begin
                for (int i = 0; i < LINE_DEPTH; i++) begin
                    r_line[i] <= '0;
                end
            end else if (shift) begin
                for (int i = LINE_DEPTH - 1; i > 0; i--) begin
                    r_line[i] <= r_line[i-1];
                end
                r_line[0] <= i_smp.sample;
            end
        end
    end

    a_flush_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (r_k >= t_half'(1) && r_k <= l))
        else $error("Flush counter left the window half width range.");

endmodule

`default_nettype wire

[sv/zpba_fifo.sv]
`default_nettype none

module zpba_fifo
    import zpba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_stat   o_stat
);

    t_job                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR-1:0] r_wp;
    logic [FIFO_PTR-1:0] r_rp;
    logic [FIFO_PTR:0]   r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (FIFO_PTR + 1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_PTR'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_PTR'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_PTR + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (FIFO_PTR + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("Queue read while empty.");

endmodule

`default_nettype wire

[sv/zpba_back.sv]
`default_nettype none

module zpba_back
    import zpba_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_half   i_half,
    input  wire t_job    i_job,
    input  wire t_q_stat i_stat,
    output logic         o_pop,
    zpba_out_if.source   o_avg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [DVD_BITS-1:0]  r_dvd;
    logic [DIV_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_last;
    logic                 r_ov;
    logic [AVG_BITS-1:0]  r_avg;
    logic                 r_lo;

    logic [DIV_BITS-1:0]  divisor;
    logic [DIV_BITS:0]    rem_sh;
    logic                 ge;
    logic [DIV_BITS-1:0]  n_rem;
    logic                 handoff;

    assign divisor = DIV_BITS'({eff_half(i_half), 1'b1});
    assign rem_sh  = {r_rem, r_dvd[DVD_BITS-1]};
    assign ge      = rem_sh >= (DIV_BITS + 1)'(divisor);
    assign n_rem   = ge ? DIV_BITS'(rem_sh - (DIV_BITS + 1)'(divisor)) : DIV_BITS'(rem_sh);
    assign o_pop   = (r_state == S_IDLE) && !i_stat.empty;
    assign handoff = (r_state == S_DONE) && (!r_ov || o_avg.ready);

    assign o_avg.valid    = r_ov;
    assign o_avg.average  = r_avg;
    assign o_avg.last_out = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (o_avg.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_dvd   <= {i_job.sum, FRAC_BITS'(0)};
                        r_rem   <= '0;
                        r_cnt   <= CNT_BITS'(DVD_BITS - 1);
                        r_last  <= i_job.last;
                        r_state <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[DVD_BITS-2:0], ge};
                    r_cnt <= r_cnt - CNT_BITS'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (handoff) begin
                        r_ov    <= 1'b1;
                        r_avg   <= r_dvd[AVG_BITS-1:0];
                        r_lo    <= r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_rem < divisor))
        else $error("Division remainder not below the divisor.");

endmodule

`default_nettype wire

[sv/zero_padded_box_average_top.sv]
// Zero-padded centered box average over 2L+1 samples, L = half_width.
// Samples of a frame enter on i_smp, one per transaction, last_in marking the
// frame's final sample. Averages leave on o_avg as unsigned Q16.8, truncated,
// last_out marking the frame's final result. Samples outside the frame count
// as zero, so every frame of N samples yields exactly N results.
// The result for position q leaves once sample q+L has been taken; it passes
// through the queue and the divider into the output register.
// The last sample releases up to L pending results, which the front end
// pushes one per cycle into a four-entry queue while that queue has room.
// Each result goes through a bit-serial restoring divider, one quotient bit
// per cycle over 29 bits; this divider sets the sustained rate. The front end
// takes a sample whenever the queue has room but stops during the flush.
// A transaction on i_cfg writes half_width (taken as 1 when zero) and starts
// a new frame; write it only while the block is idle. i_cfg is always ready.
// Reset sets half_width to 3 and clears the delay line, the window sum, the
// frame position, the queue and the output valid flag.
// When the receiver stalls, the output register holds its result, the divider
// waits with the next one, and the queue and then i_smp fill up and stall.
`default_nettype none

module zero_padded_box_average_top
    import zpba_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    zpba_cfg_if.sink  i_cfg,
    zpba_smp_if.sink  i_smp,
    zpba_out_if.source o_avg
);

    t_half   r_half;
    logic    cfg_write;
    logic    push;
    logic    pop;
    t_job    push_job;
    t_job    head_job;
    t_q_stat q_stat;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (cfg_write) begin
            r_half <= i_cfg.half_width;
        end
    end

    zpba_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_write),
        .i_half  (r_half),
        .i_smp   (i_smp),
        .i_stat  (q_stat),
        .o_push  (push),
        .o_job   (push_job)
    );

    zpba_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    zpba_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_half  (r_half),
        .i_job   (head_job),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_avg   (o_avg)
    );

endmodule

`default_nettype wire
